### rtl/kch_pkg.sv
`default_nettype none
package kch_pkg;

  localparam int MAX_KEEP      = 16;
  localparam int POSITION_BITS = 16;
  localparam int DATA_W        = 32;
  localparam int DIST_W        = 33;
  localparam int KEEP_W        = 5;
  localparam int CFG_IDX_W     = 1;
  localparam int IDX_W         = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int CNT_W         = $clog2(MAX_KEEP + 1);
  localparam int KCMP_W        = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET     = 1'b0,
    CFG_KEEP_COUNT = 1'b1
  } cfg_reg_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic init_scan;
    logic append;
    logic scan_step;
    logic replace;
    logic emit_move;
    logic clear_arrival;
  } kch_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fill_lt_k;
    logic scan_done;
    logic last_item;
    logic fill_is_one;
  } kch_status_t;

endpackage
`default_nettype wire

### rtl/kch_dp.sv
`default_nettype none
module kch_dp
  import kch_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [DATA_W-1:0]        cfg_data_i,
  input  wire logic signed [DATA_W-1:0] sample_value_i,
  input  wire logic                     last_item_i,
  input  wire kch_cmd_t                 cmd_i,
  output kch_status_t                   status_o,
  output logic signed [DATA_W-1:0]      kept_value_o,
  output logic [DATA_W-1:0]             kept_distance_o,
  output logic                          final_result_o
);

  logic signed [DATA_W-1:0] target_q;
  logic [KEEP_W-1:0]        keep_q;

  logic [CNT_W-1:0]         fill_q, fill_d;
  logic [POSITION_BITS-1:0] arrival_q, arrival_d;
  logic [CNT_W-1:0]         scan_idx_q, scan_idx_d;
  logic                     last_q;

  logic [DATA_W-1:0]        sample_q;
  logic [DIST_W-1:0]        dist_q;
  logic [POSITION_BITS-1:0] pos_q;

  logic [IDX_W-1:0]         best_idx_q;
  logic [DIST_W-1:0]        best_dist_q;
  logic [POSITION_BITS-1:0] best_pos_q;
  logic [DATA_W-1:0]        best_val_q;

  logic [DIST_W-1:0]        ent_dist_q [MAX_KEEP];
  logic [POSITION_BITS-1:0] ent_pos_q  [MAX_KEEP];
  logic [DATA_W-1:0]        ent_val_q  [MAX_KEEP];

  logic [KCMP_W-1:0]        keep_ext, keep_eff;
  logic [CNT_W-1:0]         fill_m1;
  logic [IDX_W-1:0]         rd_idx;
  logic [DIST_W-1:0]        rd_dist;
  logic [POSITION_BITS-1:0] rd_pos;
  logic [DATA_W-1:0]        rd_val;
  logic                     rd_greater;

  logic signed [DIST_W-1:0] s_ext, t_ext, diff_st, diff_ts;
  logic [DIST_W-1:0]        new_dist;

  logic                     wr_en;
  logic [IDX_W-1:0]         wr_idx;
  logic [DIST_W-1:0]        wr_dist;
  logic [POSITION_BITS-1:0] wr_pos;
  logic [DATA_W-1:0]        wr_val;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      keep_q   <= KEEP_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_TARGET:     target_q <= cfg_data_i;
        CFG_KEEP_COUNT: keep_q   <= cfg_data_i[KEEP_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp keep count into 1..MAX_KEEP
  always_comb begin
    keep_ext = KCMP_W'(keep_q);
    if (keep_ext == '0) begin
      keep_eff = KCMP_W'(1);
    end else if (keep_ext > KCMP_W'(MAX_KEEP)) begin
      keep_eff = KCMP_W'(MAX_KEEP);
    end else begin
      keep_eff = keep_ext;
    end
  end

  // both differences in parallel, pick the non-negative one
  assign s_ext    = DIST_W'(sample_value_i);
  assign t_ext    = DIST_W'(target_q);
  assign diff_st  = s_ext - t_ext;
  assign diff_ts  = t_ext - s_ext;
  assign new_dist = diff_st[DIST_W-1] ? diff_ts : diff_st;

  assign fill_m1 = fill_q - CNT_W'(1);

  always_comb begin
    if (cmd_i.init_scan) begin
      rd_idx = '0;
    end else if (cmd_i.emit_move) begin
      rd_idx = fill_m1[IDX_W-1:0];
    end else begin
      rd_idx = scan_idx_q[IDX_W-1:0];
    end
  end

  assign rd_dist = ent_dist_q[rd_idx];
  assign rd_pos  = ent_pos_q[rd_idx];
  assign rd_val  = ent_val_q[rd_idx];

  assign rd_greater = (rd_dist > best_dist_q) ||
                      ((rd_dist == best_dist_q) && (rd_pos > best_pos_q));

  // single write port into the entry store
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = best_idx_q;
    wr_dist = dist_q;
    wr_pos  = pos_q;
    wr_val  = sample_q;
    if (cmd_i.append) begin
      wr_en  = 1'b1;
      wr_idx = fill_q[IDX_W-1:0];
    end else if (cmd_i.replace) begin
      wr_en = (dist_q <= best_dist_q);
    end else if (cmd_i.emit_move) begin
      wr_en   = 1'b1;
      wr_dist = rd_dist;
      wr_pos  = rd_pos;
      wr_val  = rd_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ent_dist_q[wr_idx] <= wr_dist;
      ent_pos_q[wr_idx]  <= wr_pos;
      ent_val_q[wr_idx]  <= wr_val;
    end
  end

  always_comb begin
    fill_d     = fill_q;
    arrival_d  = arrival_q;
    scan_idx_d = scan_idx_q;
    if (cmd_i.load) begin
      arrival_d = arrival_q + POSITION_BITS'(1);
    end
    if (cmd_i.clear_arrival) begin
      arrival_d = '0;
    end
    if (cmd_i.append) begin
      fill_d = fill_q + CNT_W'(1);
    end else if (cmd_i.emit_move) begin
      fill_d = fill_m1;
    end
    if (cmd_i.init_scan) begin
      scan_idx_d = CNT_W'(1);
    end else if (cmd_i.scan_step) begin
      scan_idx_d = scan_idx_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      arrival_q  <= '0;
      scan_idx_q <= '0;
      last_q     <= 1'b0;
    end else begin
      fill_q     <= fill_d;
      arrival_q  <= arrival_d;
      scan_idx_q <= scan_idx_d;
      if (cmd_i.load) begin
        last_q <= last_item_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= sample_value_i;
      dist_q   <= new_dist;
      pos_q    <= arrival_q;
    end
    if (cmd_i.init_scan) begin
      best_idx_q  <= '0;
      best_dist_q <= rd_dist;
      best_pos_q  <= rd_pos;
      best_val_q  <= rd_val;
    end else if (cmd_i.scan_step && rd_greater) begin
      best_idx_q  <= rd_idx;
      best_dist_q <= rd_dist;
      best_pos_q  <= rd_pos;
      best_val_q  <= rd_val;
    end
  end

  assign status_o.fill_lt_k   = KCMP_W'(fill_q) < keep_eff;
  assign status_o.scan_done   = (scan_idx_q == fill_q);
  assign status_o.last_item   = last_q;
  assign status_o.fill_is_one = (fill_q == CNT_W'(1));

  assign kept_value_o    = best_val_q;
  assign kept_distance_o = best_dist_q[DATA_W-1:0];
  assign final_result_o  = (fill_q == CNT_W'(1));

endmodule
`default_nettype wire

### rtl/kch_ctrl.sv
`default_nettype none
module kch_ctrl
  import kch_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  input  wire kch_status_t status_i,
  output kch_cmd_t         cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_PLACE     = 6'b000010,
    S_SCAN      = 6'b000100,
    S_REPL      = 6'b001000,
    S_EMIT_INIT = 6'b010000,
    S_OUT       = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   emit_q, emit_d;

  always_comb begin
    state_d = state_q;
    emit_d  = emit_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        emit_d = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PLACE;
        end
      end
      S_PLACE: begin
        if (status_i.fill_lt_k) begin
          cmd_o.append = 1'b1;
          state_d      = status_i.last_item ? S_EMIT_INIT : S_IDLE;
        end else begin
          cmd_o.init_scan = 1'b1;
          state_d         = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status_i.scan_done) begin
          state_d = emit_q ? S_OUT : S_REPL;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_REPL: begin
        cmd_o.replace = 1'b1;
        state_d       = status_i.last_item ? S_EMIT_INIT : S_IDLE;
      end
      S_EMIT_INIT: begin
        cmd_o.init_scan = 1'b1;
        emit_d          = 1'b1;
        state_d         = S_SCAN;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          // refill the emitted slot from the tail of the store
          cmd_o.emit_move = 1'b1;
          if (status_i.fill_is_one) begin
            cmd_o.clear_arrival = 1'b1;
            emit_d              = 1'b0;
            state_d             = S_IDLE;
          end else begin
            state_d = S_EMIT_INIT;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      emit_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      emit_q  <= emit_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

endmodule
`default_nettype wire

### rtl/k_closest_heap_selector_top.sv
// Input: a sample is taken while idle; while the store is filling it is placed
// in the next cycle, otherwise a scan of the stored entries and a replace follow.
// A new sample is taken only once the previous one is done (in_stall_o is high until then).
// Emission: each result needs a scan for the largest key, then waits out any output stalls.
// Reset: store empty, arrival counter zero, target 0, keep count 1; entries are not cleared.
`default_nettype none
module k_closest_heap_selector_top
  import kch_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [DATA_W-1:0]        cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic signed [DATA_W-1:0] sample_value_i,
  input  wire logic                     last_item_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [DATA_W-1:0]      kept_value_o,
  output logic [DATA_W-1:0]             kept_distance_o,
  output logic                          final_result_o
);

  kch_cmd_t    cmd;
  kch_status_t status;

  kch_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  kch_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .sample_value_i  (sample_value_i),
    .last_item_i     (last_item_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .kept_value_o    (kept_value_o),
    .kept_distance_o (kept_distance_o),
    .final_result_o  (final_result_o)
  );

endmodule
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps
module tb
  import kch_pkg::*;
();

  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int SETTLE_CYCLES = 48;
  localparam int RANDOM_ITEMS  = 380;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [DATA_W-1:0]        distance;
    logic                     final_flag;
  } kept_t;

  logic                     clk_i;
  logic                     rst_ni         = 1'b0;
  logic                     cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index_i    = '0;
  logic [DATA_W-1:0]        cfg_data_i     = '0;
  logic                     in_valid_i     = 1'b0;
  logic                     in_stall_o;
  logic signed [DATA_W-1:0] sample_value_i = '0;
  logic                     last_item_i    = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i    = 1'b0;
  logic signed [DATA_W-1:0] kept_value_o;
  logic [DATA_W-1:0]        kept_distance_o;
  logic                     final_result_o;

  k_closest_heap_selector_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_value_i (sample_value_i),
    .last_item_i    (last_item_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kept_value_o   (kept_value_o),
    .kept_distance_o(kept_distance_o),
    .final_result_o (final_result_o)
  );

  // Shadow of the selector: configuration, store and arrival position
  logic signed [DATA_W-1:0]  target_reg  = '0;
  logic [KEEP_W-1:0]         keep_reg    = KEEP_W'(1);
  logic [DIST_W-1:0]         held_dist  [MAX_KEEP];
  logic [POSITION_BITS-1:0]  held_pos   [MAX_KEEP];
  logic [DATA_W-1:0]         held_value [MAX_KEEP];
  int                        held_count  = 0;
  logic [POSITION_BITS-1:0]  arrival_pos = '0;
  kept_t                     nearest_q[$];

  int  fail_count      = 0;
  int  cycle_count     = 0;
  int  samples_sent    = 0;
  int  sets_sent       = 0;
  int  results_checked = 0;
  int  reg_writes      = 0;
  bit  gaps_on         = 1'b0;
  int  burst_left      = 0;
  bit  rx_quiet        = 1'b1;
  int  stall_run       = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding", cycle_count,
             nearest_q.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  // Receiver: random runs of stalls, off while quiet
  always @(posedge clk_i) begin
    if (rx_quiet) begin
      out_stall_i <= 1'b0;
      stall_run = 0;
    end else if (stall_run != 0) begin
      out_stall_i <= 1'b1;
      stall_run--;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      stall_run = $urandom_range(0, 7);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    kept_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_checked++;
      if (nearest_q.size() == 0) begin
        $error("unexpected result: value %0d distance %0d final %0b", kept_value_o,
               kept_distance_o, final_result_o);
        fail_count++;
      end else begin
        want = nearest_q.pop_front();
        if (kept_value_o !== want.value) begin
          $error("kept_value: expected %0d, got %0d", want.value, kept_value_o);
          fail_count++;
        end
        if (kept_distance_o !== want.distance) begin
          $error("kept_distance: expected %0d, got %0d", want.distance, kept_distance_o);
          fail_count++;
        end
        if (final_result_o !== want.final_flag) begin
          $error("final_result: expected %0b, got %0b", want.final_flag, final_result_o);
          fail_count++;
        end
      end
    end
  end

  function automatic int largest_held();
    int best;
    best = 0;
    for (int i = 1; i < held_count; i++)
      if (held_dist[i] > held_dist[best] ||
          (held_dist[i] == held_dist[best] && held_pos[i] > held_pos[best]))
        best = i;
    return best;
  endfunction

  task automatic predict_nearest(input logic [DATA_W-1:0] value, input logic last);
    longint      diff;
    logic [DIST_W-1:0] sample_dist;
    int          limit;
    int          m;
    int          tail;
    kept_t       res;
    diff = longint'($signed(value)) - longint'(target_reg);
    if (diff < 0) diff = -diff;
    sample_dist = diff[DIST_W-1:0];
    limit = (keep_reg == 0) ? 1 : (keep_reg > MAX_KEEP) ? MAX_KEEP : int'(keep_reg);
    if (held_count < limit) begin
      held_dist[held_count]  = sample_dist;
      held_pos[held_count]   = arrival_pos;
      held_value[held_count] = value;
      held_count++;
    end else begin
      m = largest_held();
      if (sample_dist <= held_dist[m]) begin
        held_dist[m]  = sample_dist;
        held_pos[m]   = arrival_pos;
        held_value[m] = value;
      end
    end
    arrival_pos++;
    if (last) begin
      // empty the store, largest key first; the tail entry fills the hole
      while (held_count > 0) begin
        m = largest_held();
        tail = held_count - 1;
        res.value      = held_value[m];
        res.distance   = held_dist[m][DATA_W-1:0];
        res.final_flag = (tail == 0);
        nearest_q = {nearest_q, res};
        held_dist[m]  = held_dist[tail];
        held_pos[m]   = held_pos[tail];
        held_value[m] = held_value[tail];
        held_count = tail;
      end
      arrival_pos = '0;
      sets_sent++;
    end
  endtask

  task automatic send_sample(input logic [DATA_W-1:0] value, input logic last);
    int gap;
    sample_value_i <= value;
    last_item_i    <= last;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_nearest(value, last);
    samples_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 12);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Drop valid, wait for every result, then let the block settle
  task automatic wait_idle();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (nearest_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [DATA_W-1:0] data);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    if (idx == CFG_TARGET) target_reg = data;
    else keep_reg = data[KEEP_W-1:0];
    reg_writes++;
    cfg_we_i <= 1'b0;
  endtask

  // Upper bits of the write word carry noise
  task automatic write_keep(input int count);
    logic [DATA_W-1:0] word;
    word = $urandom;
    word[KEEP_W-1:0] = KEEP_W'(count);
    write_reg(CFG_KEEP_COUNT, word);
  endtask

  function automatic logic [DATA_W-1:0] pick_target();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return DATA_W'($urandom_range(0, 200)) - 32'd100;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_keep();
    case ($urandom_range(0, 9))
      0:       return 1;
      1:       return MAX_KEEP;
      2:       return $urandom_range(0, 1) ? 0 : $urandom_range(MAX_KEEP + 1, 31);
      default: return $urandom_range(1, MAX_KEEP);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_value(input int style);
    case (style)
      0:       return $urandom;
      1:       return target_reg + DATA_W'($urandom_range(0, 16)) - 32'd8;
      2:       return target_reg + DATA_W'($urandom_range(0, 1 << 17)) - 32'h1_0000;
      default:
        case ($urandom_range(0, 4))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return target_reg + 32'd1;
          3:       return target_reg - 32'd1;
          default: return $urandom;
        endcase
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_sample(32'd5, 1'b0);
    send_sample(-32'sd3, 1'b1);
  endtask

  task automatic test_field_extremes();
    write_reg(CFG_TARGET, 32'h7FFF_FFFF);
    write_keep(4);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b1);
    write_reg(CFG_TARGET, 32'h8000_0000);
    send_sample(32'h7FFF_FFFF, 1'b1);
  endtask

  task automatic test_tie_newer_wins();
    write_reg(CFG_TARGET, 32'd1000);
    write_keep(3);
    send_sample(32'd1003, 1'b0);
    send_sample(32'd997, 1'b0);
    send_sample(32'd1003, 1'b0);
    send_sample(32'd997, 1'b0);
    send_sample(32'd1000, 1'b0);
    send_sample(32'd1002, 1'b1);
  endtask

  task automatic test_keep_out_of_range();
    write_keep(0);
    send_sample(32'd10, 1'b0);
    send_sample(32'd11, 1'b1);
    write_keep(MAX_KEEP + 4);
    send_sample(32'd900, 1'b0);
    send_sample(-32'sd900, 1'b1);
  endtask

  task automatic test_keep_lowered_midset();
    write_reg(CFG_TARGET, 32'd0);
    write_keep(6);
    send_sample(32'd40, 1'b0);
    send_sample(-32'sd10, 1'b0);
    send_sample(32'd25, 1'b0);
    send_sample(32'd7, 1'b0);
    write_keep(2);
    send_sample(32'd20, 1'b0);
    send_sample(-32'sd7, 1'b1);
  endtask

  task automatic test_target_moved_midset();
    send_sample(32'd50, 1'b0);
    send_sample(-32'sd20, 1'b0);
    write_reg(CFG_TARGET, 32'd40);
    send_sample(32'd45, 1'b1);
  endtask

  task automatic test_random_sets();
    int sent;
    int len;
    int style;
    int change_at;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      rx_quiet <= ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 1)) write_reg(CFG_TARGET, pick_target());
      if ($urandom_range(0, 1)) write_keep(pick_keep());
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 18);
      style = $urandom_range(0, 3);
      change_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, len) : 0;
      for (int i = 0; i < len; i++) begin
        if (i == change_at && i != 0) begin
          if ($urandom_range(0, 1)) write_keep(pick_keep());
          else write_reg(CFG_TARGET, pick_target());
        end
        send_sample(pick_value(style), i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    rx_quiet <= 1'b0;
    gaps_on = 1'b1;
    test_field_extremes();
    test_tie_newer_wins();
    test_keep_out_of_range();
    test_keep_lowered_midset();
    test_target_moved_midset();
    test_random_sets();
    wait_idle();
    $display("Covered %0d samples in %0d sets with %0d register writes; %0d results checked.",
             samples_sent, sets_sent, reg_writes, results_checked);
    $display("Included extreme distances, ties, out-of-range keep counts "
             , "and mid-set changes.");
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
